### rtl/core/tfn_pkg.sv
package tfn_pkg;

    localparam int AXES      = 3;
    localparam int OUT_W     = 16;  // width of one normal component on the port
    localparam int EDGE_W    = 31;  // edges are kept below 2^30 in magnitude
    localparam int SCALE_MSB = 30;  // largest scaled magnitude lies in [2^30, 2^31)
    localparam int MAG_W     = 31;
    localparam int SQ_IN_W   = 64;
    localparam int SQ_ROOT_W = 32;
    localparam int SQ_REM_W  = 35;
    localparam int SQ_PER    = 2;   // root bits per sqrt stage
    localparam int DV_PER    = 2;   // quotient bits per divider stage
    localparam int DEN_W     = 32;

    typedef struct packed {
        logic [AXES-1:0] neg;
        logic            degen;
    } tfn_flags_t;

endpackage

### rtl/core/tfn_isqrt.sv
module tfn_isqrt (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [tfn_pkg::SQ_IN_W-1:0]    x,
    output logic [tfn_pkg::SQ_ROOT_W-1:0]  root
);
    import tfn_pkg::*;

    localparam int ST = SQ_ROOT_W / SQ_PER;

    logic [SQ_IN_W-1:0]   rad_reg  [ST];
    logic [SQ_REM_W-1:0]  rem_reg  [ST];
    logic [SQ_ROOT_W-1:0] root_reg [ST];

    for (genvar s = 0; s < ST; s++) begin : g_st
        // previous stage index, clamped so stage 0 never indexes below the array
        localparam int PREV = (s == 0) ? 0 : s - 1;

        logic [SQ_IN_W-1:0]   rad_next;
        logic [SQ_REM_W-1:0]  rem_next;
        logic [SQ_ROOT_W-1:0] root_next;

        always_comb begin
            logic [SQ_REM_W-1:0] rt;
            logic [SQ_REM_W-1:0] trial;
            if (s == 0) begin
                rad_next  = x;
                rem_next  = '0;
                root_next = '0;
            end else begin
                rad_next  = rad_reg[PREV];
                rem_next  = rem_reg[PREV];
                root_next = root_reg[PREV];
            end
            for (int j = 0; j < SQ_PER; j++) begin
                rt       = {rem_next[SQ_REM_W-3:0], rad_next[SQ_IN_W-1 -: 2]};
                rad_next = rad_next << 2;
                trial    = (SQ_REM_W'(root_next) << 2) | SQ_REM_W'(1);
                if (rt >= trial) begin
                    rem_next  = rt - trial;
                    root_next = (root_next << 1) | SQ_ROOT_W'(1);
                end else begin
                    rem_next  = rt;
                    root_next = root_next << 1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[s]  <= rad_next;
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
            end
        end
    end

    assign root = root_reg[ST-1];

endmodule

### rtl/core/tfn_div.sv
module tfn_div #(
    parameter int NUM_W = 46,
    parameter int QUO_W = 16
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [NUM_W-1:0]           num [tfn_pkg::AXES],
    input  logic [tfn_pkg::DEN_W-1:0]  den,
    output logic [QUO_W-1:0]           quo [tfn_pkg::AXES]
);
    import tfn_pkg::*;

    localparam int ST  = QUO_W / DV_PER;
    localparam int RMW = DEN_W + 1;

    logic [RMW-1:0]   rem_reg [ST][AXES];
    logic [QUO_W-1:0] bit_reg [ST][AXES];
    logic [QUO_W-1:0] q_reg   [ST][AXES];
    logic [DEN_W-1:0] den_reg [ST];

    for (genvar s = 0; s < ST; s++) begin : g_st
        // previous stage index, clamped so stage 0 never indexes below the array
        localparam int PREV = (s == 0) ? 0 : s - 1;

        logic [RMW-1:0]   rem_next [AXES];
        logic [QUO_W-1:0] bit_next [AXES];
        logic [QUO_W-1:0] q_next   [AXES];
        logic [DEN_W-1:0] d;

        always_comb begin
            logic [RMW-1:0] t;
            d = (s == 0) ? den : den_reg[PREV];
            for (int i = 0; i < AXES; i++) begin
                if (s == 0) begin
                    // quotient fits QUO_W bits, so the upper part is below den
                    rem_next[i] = RMW'(num[i] >> QUO_W);
                    bit_next[i] = num[i][QUO_W-1:0];
                    q_next[i]   = '0;
                end else begin
                    rem_next[i] = rem_reg[PREV][i];
                    bit_next[i] = bit_reg[PREV][i];
                    q_next[i]   = q_reg[PREV][i];
                end
                for (int j = 0; j < DV_PER; j++) begin
                    t           = {rem_next[i][RMW-2:0], bit_next[i][QUO_W-1]};
                    bit_next[i] = bit_next[i] << 1;
                    if (t >= RMW'(d)) begin
                        rem_next[i] = t - RMW'(d);
                        q_next[i]   = (q_next[i] << 1) | QUO_W'(1);
                    end else begin
                        rem_next[i] = t;
                        q_next[i]   = q_next[i] << 1;
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[s] <= d;
                for (int i = 0; i < AXES; i++) begin
                    rem_reg[s][i] <= rem_next[i];
                    bit_reg[s][i] <= bit_next[i];
                    q_reg[s][i]   <= q_next[i];
                end
            end
        end
    end

    for (genvar i = 0; i < AXES; i++) begin : g_out
        assign quo[i] = q_reg[ST-1][i];
    end

endmodule

### rtl/core/triangle_face_normal.sv
// Unit face normal of a triangle, one triangle per clock. A transaction on the
// slave side carries three vertices; the result is (v2-v0) x (v1-v0) scaled to
// unit length in signed Q1.NORMAL_FRAC_BITS, or the zero vector with the
// degenerate flag in m_tuser when the cross product is zero. The pipeline takes
// a new triangle every cycle while it is not stalled; the square root resolves
// two root bits in each of its 16 stages and each divider stage yields two
// quotient bits for all three components. A skid register at the output holds
// one result while m_tready is low; the pipeline stalls as a whole only once
// that is full.
module triangle_face_normal #(
    parameter int COORD_WIDTH      = 16,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z (COORD_WIDTH each)
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]       s_tdata,

    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // normal_x, normal_y, normal_z
    output logic [3*tfn_pkg::OUT_W-1:0]              m_tdata,
    // degenerate
    output logic [0:0]                               m_tuser
);
    import tfn_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int F     = NORMAL_FRAC_BITS;
    localparam int EW    = CW + 1;
    localparam int RW    = (EW > EDGE_W) ? EDGE_W : EW;
    localparam int PW    = 2 * RW;
    localparam int XW    = PW + 1;
    localparam int MW    = PW;
    localparam int PSW   = $clog2(MW);
    localparam int SHW   = (MW > MAG_W) ? MW : MAG_W;
    localparam int QW    = F + 1;
    localparam int DV_ST = (QW + DV_PER - 1) / DV_PER;
    localparam int TOTB  = DV_ST * DV_PER;
    localparam int NW    = MAG_W + F + 1;
    localparam int SQ_ST = SQ_ROOT_W / SQ_PER;
    localparam int QXW   = (TOTB > OUT_W) ? TOTB : OUT_W;

    localparam int ST_SUM = 7;
    localparam int ST_PRE = ST_SUM + SQ_ST + 1;
    localparam int ST_OUT = ST_PRE + DV_ST + 1;
    localparam int NS     = ST_OUT + 1;

    localparam logic [TOTB-1:0] QMAX = {{(TOTB-1){1'b0}}, 1'b1} << F;

    // ---------------- pipeline control ----------------
    logic          en;
    logic [NS-1:0] vld_reg, vld_next;
    logic          skid_vld_reg, skid_vld_next;

    assign en       = !skid_vld_reg;
    assign s_tready = en;
    assign vld_next = en ? {vld_reg[NS-2:0], s_tvalid} : vld_reg;

    always_comb begin
        skid_vld_next = skid_vld_reg;
        if (skid_vld_reg && m_tready) begin
            skid_vld_next = 1'b0;
        end else if (en && vld_reg[NS-1] && !m_tready) begin
            skid_vld_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            skid_vld_reg <= 1'b0;
        end else begin
            vld_reg      <= vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    // ---------------- stage 0: edges ----------------
    logic signed [EW-1:0] e_reg [2*AXES];  // e1 x,y,z then e2 x,y,z

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < AXES; i++) begin
                e_reg[i]      <= EW'($signed(s_tdata[(3+i)*CW +: CW]))
                               - EW'($signed(s_tdata[i*CW +: CW]));
                e_reg[AXES+i] <= EW'($signed(s_tdata[(6+i)*CW +: CW]))
                               - EW'($signed(s_tdata[i*CW +: CW]));
            end
        end
    end

    // ---------------- stage 1: keep edges below 2^30 ----------------
    logic signed [RW-1:0] red_c [2*AXES];
    logic signed [RW-1:0] r_reg [2*AXES];

    if (EW > RW) begin : g_red
        always_comb begin
            logic [EW-1:0] mg [2*AXES];
            logic [EW-1:0] orv;
            logic [EW-1:0] tmp;
            logic [EW-1:0] val;
            int            rk;
            orv = '0;
            for (int i = 0; i < 2*AXES; i++) begin
                mg[i] = e_reg[i][EW-1] ? EW'(-e_reg[i]) : EW'(e_reg[i]);
                orv   = orv | mg[i];
            end
            rk = 0;
            for (int b = RW - 1; b < EW; b++) begin
                if (orv[b]) rk = b - (RW - 2);
            end
            // repeated halving toward zero is a shift of the magnitude
            for (int i = 0; i < 2*AXES; i++) begin
                tmp      = mg[i] >> rk;
                val      = e_reg[i][EW-1] ? -tmp : tmp;
                red_c[i] = $signed(val[RW-1:0]);
            end
        end
    end else begin : g_nored
        always_comb begin
            for (int i = 0; i < 2*AXES; i++) red_c[i] = e_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 2*AXES; i++) r_reg[i] <= red_c[i];
        end
    end

    // ---------------- stage 2: products ----------------
    logic signed [PW-1:0] p_reg [2*AXES];

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg[0] <= r_reg[4] * r_reg[2];
            p_reg[1] <= r_reg[5] * r_reg[1];
            p_reg[2] <= r_reg[5] * r_reg[0];
            p_reg[3] <= r_reg[3] * r_reg[2];
            p_reg[4] <= r_reg[3] * r_reg[1];
            p_reg[5] <= r_reg[4] * r_reg[0];
        end
    end

    // ---------------- stage 3: cross product, sign and magnitude ----------------
    logic [MW-1:0]   mag3_reg [AXES];
    logic [AXES-1:0] neg3_reg;

    always_ff @(posedge aclk) begin
        logic signed [XW-1:0] n;
        logic [XW-1:0]        a;
        if (en) begin
            for (int i = 0; i < AXES; i++) begin
                n           = XW'(p_reg[2*i]) - XW'(p_reg[2*i+1]);
                a           = n[XW-1] ? XW'(-n) : XW'(n);
                mag3_reg[i] <= a[MW-1:0];
                neg3_reg[i] <= n[XW-1];
            end
        end
    end

    // ---------------- stage 4: leading one of the largest magnitude ----------------
    logic [MW-1:0]  mag4_reg [AXES];
    logic [PSW-1:0] pos4_reg;
    tfn_flags_t     f4_reg;

    always_ff @(posedge aclk) begin
        logic [MW-1:0]  orv;
        logic [PSW-1:0] p;
        if (en) begin
            orv = mag3_reg[0] | mag3_reg[1] | mag3_reg[2];
            p   = '0;
            for (int b = 0; b < MW; b++) begin
                if (orv[b]) p = PSW'(b);
            end
            for (int i = 0; i < AXES; i++) mag4_reg[i] <= mag3_reg[i];
            pos4_reg     <= p;
            f4_reg.neg   <= neg3_reg;
            f4_reg.degen <= (orv == '0);
        end
    end

    // ---------------- stage 5: common scaling ----------------
    logic [MAG_W-1:0] m5_reg [AXES];
    tfn_flags_t       f5_reg;

    always_ff @(posedge aclk) begin
        logic [SHW-1:0] w;
        int             ps;
        if (en) begin
            ps = int'(pos4_reg);
            for (int i = 0; i < AXES; i++) begin
                w = SHW'(mag4_reg[i]);
                if (ps >= SCALE_MSB) w = w >> (ps - SCALE_MSB);
                else                 w = w << (SCALE_MSB - ps);
                m5_reg[i] <= w[MAG_W-1:0];
            end
            f5_reg <= f4_reg;
        end
    end

    // ---------------- stage 6: squares, stage 7: sum ----------------
    logic [2*MAG_W-1:0] sq_reg [AXES];
    logic [MAG_W-1:0]   m6_reg [AXES];
    logic [MAG_W-1:0]   m7_reg [AXES];
    tfn_flags_t         f6_reg, f7_reg;
    logic [SQ_IN_W-1:0] sum_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < AXES; i++) begin
                sq_reg[i] <= (2*MAG_W)'(m5_reg[i]) * (2*MAG_W)'(m5_reg[i]);
                m6_reg[i] <= m5_reg[i];
                m7_reg[i] <= m6_reg[i];
            end
            f6_reg  <= f5_reg;
            f7_reg  <= f6_reg;
            sum_reg <= SQ_IN_W'(sq_reg[0]) + SQ_IN_W'(sq_reg[1]) + SQ_IN_W'(sq_reg[2]);
        end
    end

    // ---------------- square root ----------------
    logic [SQ_ROOT_W-1:0] root_w;
    logic [MAG_W-1:0]     sm_reg [SQ_ST][AXES];
    tfn_flags_t           sf_reg [SQ_ST];

    tfn_isqrt u_isqrt (
        .aclk (aclk),
        .en   (en),
        .x    (sum_reg),
        .root (root_w)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < SQ_ST; s++) begin
                for (int i = 0; i < AXES; i++) begin
                    sm_reg[s][i] <= (s == 0) ? m7_reg[i] : sm_reg[(s == 0) ? 0 : s-1][i];
                end
                sf_reg[s] <= (s == 0) ? f7_reg : sf_reg[(s == 0) ? 0 : s-1];
            end
        end
    end

    // ---------------- dividend with rounding term ----------------
    logic [NW-1:0]    num_reg [AXES];
    logic [DEN_W-1:0] den_reg;
    tfn_flags_t       pf_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < AXES; i++) begin
                num_reg[i] <= (NW'(sm_reg[SQ_ST-1][i]) << F) + NW'(root_w >> 1);
            end
            den_reg <= root_w;
            pf_reg  <= sf_reg[SQ_ST-1];
        end
    end

    // ---------------- division ----------------
    logic [TOTB-1:0] q_w [AXES];
    tfn_flags_t      df_reg [DV_ST];

    tfn_div #(
        .NUM_W (NW),
        .QUO_W (TOTB)
    ) u_div (
        .aclk (aclk),
        .en   (en),
        .num  (num_reg),
        .den  (den_reg),
        .quo  (q_w)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < DV_ST; s++) begin
                df_reg[s] <= (s == 0) ? pf_reg : df_reg[(s == 0) ? 0 : s-1];
            end
        end
    end

    // ---------------- output stage and skid ----------------
    logic [3*OUT_W-1:0] out_reg, skid_reg;
    logic               deg_reg, skid_deg_reg;

    always_ff @(posedge aclk) begin
        logic [QXW-1:0] qx;
        if (en) begin
            for (int i = 0; i < AXES; i++) begin
                qx = QXW'(q_w[i]);
                if (df_reg[DV_ST-1].neg[i]) qx = -qx;
                out_reg[i*OUT_W +: OUT_W] <= df_reg[DV_ST-1].degen ? '0 : qx[OUT_W-1:0];
            end
            deg_reg <= df_reg[DV_ST-1].degen;
        end
        if (en && vld_reg[NS-1] && !m_tready) begin
            skid_reg     <= out_reg;
            skid_deg_reg <= deg_reg;
        end
    end

    assign m_tvalid   = skid_vld_reg || vld_reg[NS-1];
    assign m_tdata    = skid_vld_reg ? skid_reg : out_reg;
    assign m_tuser[0] = skid_vld_reg ? skid_deg_reg : deg_reg;

    // ---------------- assertions ----------------
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("degenerate result with nonzero normal");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_vld_reg) |-> $past(vld_reg[NS-1] && !m_tready))
        else $error("skid filled without a stalled result");

    a_root_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[ST_PRE-1] && !sf_reg[SQ_ST-1].degen |-> root_w[SQ_ROOT_W-1 -: 2] != 2'b00)
        else $error("square root below scaled range");

    a_quo_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[ST_OUT-1] && !df_reg[DV_ST-1].degen
            |-> q_w[0] <= QMAX && q_w[1] <= QMAX && q_w[2] <= QMAX)
        else $error("normal component above one");

    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg && m_tready |=> !skid_vld_reg)
        else $error("skid not drained after transaction");

endmodule
